[sv/tme_pkg.sv]
// Shared types and constants for the tape machine instruction executor.
// No dependencies; imported by the top level and its checker.
package tme_pkg;

  // Configuration port geometry
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int REG_SEL_BIT = 2;

  // Fixed field widths
  localparam int TS_W   = 16;
  localparam int CL_W   = 17;
  localparam int CI_W   = 17;
  localparam int MOVE_W = 16;
  localparam int JUMP_W = 17;

  localparam logic [TS_W-1:0] TAPE_LEN_RST    = 16'd30000;
  localparam logic [CL_W-1:0] CODE_LENGTH_RST = '0;

  // Register select, taken from the word address bit
  typedef enum logic {
    REG_TAPE_LEN    = 1'b0,
    REG_CODE_LENGTH = 1'b1
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_READY,
    ST_DIVIDE,
    ST_RESOLVE,
    ST_EXEC
  } tme_state_t;

  // Instruction fields held while the tape cell is fetched
  typedef struct packed {
    logic [7:0]               add;
    logic                     print;
    logic                     read;
    logic signed [JUMP_W-1:0] jump;
    logic [7:0]               in_byte;
    logic                     halt;
  } instr_t;

endpackage

[sv/tape_machine_instruction_executor_top.sv]
// Tape machine instruction executor: tape memory, pointer wrap unit, branch logic.
// Depends on tme_pkg.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  input    | in_valid / in_stall  | move, add, print, read, jump, in_byte
//  result   | res_valid / res_stall| out_byte, out_valid, next_code_index, halted
//  config   | APB psel/penable     | tape_len @ 0x0, code_length @ 0x4
//
// An instruction reads its tape cell, then modifies and writes it back, when the
// moved pointer lands within one tape size of the range; otherwise the shift-subtract
// remainder unit and a sign fixup run first. A halted step skips the tape access.
// After reset the tape is cleared one cell a cycle: in_stall stays high until every cell is written.
// A stalled result waits in the output register; the next instruction still enters
// and holds at the write-back step until that register frees.
module tape_machine_instruction_executor_top
  import tme_pkg::*;
#(
  parameter int TAPE_DEPTH = 32768,
  parameter int CODE_DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     rst,
  // instruction channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [MOVE_W-1:0] move,
  input  logic [7:0]               add,
  input  logic                     print,
  input  logic                     read,
  input  logic signed [JUMP_W-1:0] jump,
  input  logic [7:0]               in_byte,
  // result channel
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic [7:0]               out_byte,
  output logic                     out_valid,
  output logic [CI_W-1:0]          next_code_index,
  output logic                     halted,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  localparam int AW = $clog2(TAPE_DEPTH);
  localparam int SW = AW + 1;
  localparam int ZW = (SW > TS_W) ? SW : TS_W;
  localparam int PW = ((AW > MOVE_W) ? AW : MOVE_W) + 2;
  localparam int MW = PW - 1;
  localparam int NW = $clog2(MW + 1);
  localparam int CDW = $clog2(CODE_DEPTH + 1);
  localparam int LW = (CDW > CI_W) ? CDW : CI_W;

  localparam logic [ZW-1:0] DEPTH_Z      = ZW'(TAPE_DEPTH);
  localparam logic [SW-1:0] DEPTH_S      = SW'(TAPE_DEPTH);
  localparam logic [LW-1:0] CODE_DEPTH_L = LW'(CODE_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR    = AW'(TAPE_DEPTH - 1);
  localparam logic [NW-1:0] DIV_LAST     = NW'(MW - 1);

  // configuration registers
  logic [TS_W-1:0] tape_len;
  logic [CL_W-1:0] code_length;

  // control state
  tme_state_t      state, state_next;
  logic [AW-1:0]   clr_addr;
  logic [AW-1:0]   tape_pointer;
  logic [CI_W-1:0] code_pointer;

  // held instruction and remainder unit
  instr_t          instr;
  logic            p_neg_r;
  logic [MW-1:0]   mag;
  logic [SW-1:0]   rem;
  logic [NW-1:0]   div_cnt;

  // tape memory
  logic [7:0]      tape_cells [TAPE_DEPTH];
  logic [7:0]      rdata;
  logic            mem_re, mem_we;
  logic [AW-1:0]   raddr, waddr;
  logic [7:0]      wdata;

  // output register payload
  logic [7:0]      out_byte_r;
  logic            out_valid_r;
  logic [CI_W-1:0] nci_r;
  logic            halted_r;

  logic            accept, exec_fire, out_free;

  //--------------------------------------------------------------------------
  // Configuration port
  //--------------------------------------------------------------------------
  reg_idx_t reg_sel;
  assign reg_sel = reg_idx_t'(paddr[REG_SEL_BIT]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tape_len    <= TAPE_LEN_RST;
      code_length <= CODE_LENGTH_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_TAPE_LEN:    tape_len    <= pwdata[TS_W-1:0];
        REG_CODE_LENGTH: code_length <= pwdata[CL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TAPE_LEN:    prdata = DATA_W'(tape_len);
      REG_CODE_LENGTH: prdata = DATA_W'(code_length);
      default:         prdata = '0;
    endcase
  end

  //--------------------------------------------------------------------------
  // Effective tape size and code length
  //--------------------------------------------------------------------------
  logic [ZW-1:0] ts_z;
  logic [SW-1:0] size;
  logic [LW-1:0] cl_l, len;
  logic          halt_now;

  assign ts_z = ZW'(tape_len);
  assign size = (tape_len == '0) ? SW'(1) :
                (ts_z > DEPTH_Z)  ? DEPTH_S : SW'(ts_z);
  assign cl_l = LW'(code_length);
  assign len  = (cl_l > CODE_DEPTH_L) ? CODE_DEPTH_L : cl_l;
  assign halt_now = (LW'(code_pointer) >= len);

  //--------------------------------------------------------------------------
  // Pointer move: single-correction fast path
  //--------------------------------------------------------------------------
  logic signed [PW-1:0] size_p, p_sum, p_lo, p_hi, fast_r;
  logic                 p_neg, fast_ok;
  logic [MW-1:0]        mag_init;

  assign size_p = $signed(PW'(size));
  assign p_sum  = $signed(PW'(tape_pointer)) + PW'(move);
  assign p_lo   = p_sum - size_p;
  assign p_hi   = p_sum + size_p;
  assign p_neg  = p_sum[PW-1];

  always_comb begin
    fast_ok = 1'b1;
    fast_r  = p_sum;
    if (!p_neg && (p_sum < size_p)) begin
      fast_r = p_sum;
    end else if (!p_neg && (p_lo < size_p)) begin
      fast_r = p_lo;
    end else if (p_neg && !p_hi[PW-1]) begin
      fast_r = p_hi;
    end else begin
      fast_ok = 1'b0;
    end
  end

  assign mag_init = p_neg ? MW'(-p_sum) : MW'(p_sum);

  //--------------------------------------------------------------------------
  // Remainder unit: one quotient bit per cycle, sign fixup at the end
  //--------------------------------------------------------------------------
  logic [SW-1:0] trial, rem_next, res_r;

  assign trial    = {rem[SW-2:0], mag[MW-1]};
  assign rem_next = (trial >= size) ? (trial - size) : trial;
  assign res_r    = (p_neg_r && (rem != '0)) ? (size - rem) : rem;

  //--------------------------------------------------------------------------
  // Cell update and branch
  //--------------------------------------------------------------------------
  logic [7:0]      cell_sum, cell_new;
  logic            taken;
  logic [CI_W-1:0] cp_inc, cp_jmp, ci_next;

  assign cell_sum = rdata + instr.add;
  assign cell_new = instr.read ? instr.in_byte : cell_sum;
  assign taken    = (!instr.jump[JUMP_W-1] && (instr.jump != '0) && (cell_new == 8'd0)) ||
                    (instr.jump[JUMP_W-1] && (cell_new != 8'd0));
  assign cp_inc   = code_pointer + CI_W'(1);
  assign cp_jmp   = code_pointer + CI_W'(1) + CI_W'($unsigned(instr.jump));
  assign ci_next  = taken ? cp_jmp : cp_inc;

  //--------------------------------------------------------------------------
  // Sequencer: next state
  //--------------------------------------------------------------------------
  assign out_free = !res_valid || !res_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:   if (clr_addr == LAST_ADDR) state_next = ST_READY;
      ST_READY: begin
        if (in_valid) begin
          if (halt_now || fast_ok) state_next = ST_EXEC;
          else                     state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE:  if (div_cnt == DIV_LAST) state_next = ST_RESOLVE;
      ST_RESOLVE: state_next = ST_EXEC;
      ST_EXEC:    if (out_free) state_next = ST_READY;
      default:    state_next = ST_CLEAR;
    endcase
  end

  //--------------------------------------------------------------------------
  // Sequencer: outputs and memory port control
  //--------------------------------------------------------------------------
  always_comb begin
    in_stall  = 1'b1;
    accept    = 1'b0;
    exec_fire = 1'b0;
    mem_re    = 1'b0;
    raddr     = AW'(fast_r);
    mem_we    = 1'b0;
    waddr     = tape_pointer;
    wdata     = cell_new;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_addr;
        wdata  = 8'd0;
      end
      ST_READY: begin
        in_stall = 1'b0;
        accept   = in_valid;
        mem_re   = in_valid && !halt_now && fast_ok;
      end
      ST_RESOLVE: begin
        mem_re = 1'b1;
        raddr  = AW'(res_r);
      end
      ST_EXEC: begin
        exec_fire = out_free;
        mem_we    = out_free && !instr.halt;
      end
      default: ;
    endcase
  end

  //--------------------------------------------------------------------------
  // Control registers
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      tape_pointer <= '0;
      code_pointer <= '0;
      res_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (mem_re) tape_pointer <= raddr;
      if (exec_fire && !instr.halt) code_pointer <= ci_next;
      if (exec_fire)     res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  //--------------------------------------------------------------------------
  // Instruction hold and remainder datapath
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      instr   <= '{add: add, print: print, read: read, jump: jump,
                   in_byte: in_byte, halt: halt_now};
      p_neg_r <= p_neg;
      mag     <= mag_init;
      rem     <= '0;
      div_cnt <= '0;
    end else if (state == ST_DIVIDE) begin
      mag     <= {mag[MW-2:0], 1'b0};
      rem     <= rem_next;
      div_cnt <= div_cnt + NW'(1);
    end
  end

  //--------------------------------------------------------------------------
  // Tape memory, one write and one registered read port
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) tape_cells[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rdata <= tape_cells[raddr];
  end

  //--------------------------------------------------------------------------
  // Result register
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_valid_r <= !instr.halt && instr.print;
      out_byte_r  <= (!instr.halt && instr.print) ? cell_sum : 8'd0;
      nci_r       <= instr.halt ? code_pointer : ci_next;
      halted_r    <= instr.halt;
    end
  end

  assign out_byte        = out_byte_r;
  assign out_valid       = out_valid_r;
  assign next_code_index = nci_r;
  assign halted          = halted_r;

endmodule

[sv/tme_checker.sv]
// Port-level checker for the tape machine instruction executor, with its bind.
// Depends on tme_pkg and tape_machine_instruction_executor_top.
module tme_checker
  import tme_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input logic            res_valid,
  input logic            res_stall,
  input logic [7:0]      out_byte,
  input logic            out_valid,
  input logic [CI_W-1:0] next_code_index,
  input logic            halted
);

  // an accepted instruction raises in_stall
  a_two_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("instruction accepted on consecutive cycles");

  // a halted step prints nothing
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && halted |-> !out_valid && (out_byte == 8'd0))
    else $error("halted result carries output");

  // no print value without its flag
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_valid |-> (out_byte == 8'd0))
    else $error("out_byte nonzero without out_valid");

  // stalled result transaction holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(out_byte) && $stable(out_valid)
      && $stable(next_code_index) && $stable(halted))
    else $error("stalled result changed");

endmodule

bind tape_machine_instruction_executor_top tme_checker u_tme_checker (.*);
